// ===== design/pattern_occurrence_counter_assert.svh =====
// ----------------------------------------------------------------------------
// pattern_occurrence_counter_assert.svh
// Assertion macros used by the checker file poc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef PATTERN_OCCURRENCE_COUNTER_ASSERT_SVH
`define PATTERN_OCCURRENCE_COUNTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define POC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pattern_occurrence_counter assertion failed");

// next-cycle implication, disabled during reset
`define POC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pattern_occurrence_counter assertion failed");

`endif

// ===== design/poc_pkg.sv =====
// ----------------------------------------------------------------------------
// poc_pkg
// Shared constants and types of the pattern occurrence counter.
// ----------------------------------------------------------------------------
`default_nettype none

package poc_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int OUT_COUNT_W     = 16;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  typedef struct packed {
    logic text_shift;
    logic pat_shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/poc_cell.sv =====
// ----------------------------------------------------------------------------
// poc_cell
// One matcher cell: holds one text word and one pattern word, shifts both
// on to its neighbour and flags whether its position agrees or lies past the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module poc_cell #(
  parameter int IDX         = 0,
  parameter int VALUE_WIDTH = poc_pkg::VALUE_WIDTH_DEF,
  parameter int LEN_W       = 5
) (
  input  wire                     clk,
  input  poc_pkg::cell_ctrl_t     ctrl,
  input  wire  [VALUE_WIDTH-1:0]  text_in,
  output logic [VALUE_WIDTH-1:0]  text_out,
  input  wire  [VALUE_WIDTH-1:0]  pat_in,
  output logic [VALUE_WIDTH-1:0]  pat_out,
  input  wire  [LEN_W-1:0]        plen,
  output logic                    hit
);

  localparam logic [LEN_W:0] MY_IDX = (LEN_W + 1)'(IDX);

  logic [VALUE_WIDTH-1:0] text_r;
  logic [VALUE_WIDTH-1:0] pat_r;

  always_ff @(posedge clk) begin
    if (ctrl.text_shift) begin
      text_r <= text_in;
    end
    if (ctrl.pat_shift) begin
      pat_r <= pat_in;
    end
  end

  // incoming word is this position's text after the shift
  assign hit      = (MY_IDX >= {1'b0, plen}) || (text_in == pat_r);
  assign text_out = text_r;
  assign pat_out  = pat_r;

endmodule

`default_nettype wire

// ===== design/pattern_occurrence_counter.sv =====
// ----------------------------------------------------------------------------
// pattern_occurrence_counter
// Output: a result appears on out_ in the cycle after the last text beat.
// Throughput: one beat per cycle while in_stall is low; the cell row compares all positions at once.
// Reset: synchronous rst_n clears lengths, running counts, overflow and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_occurrence_counter #(
  parameter int PATTERN_MAX = poc_pkg::PATTERN_MAX_DEF,
  parameter int VALUE_WIDTH = poc_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = poc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_req_type,
  input  wire  signed [VALUE_WIDTH-1:0]      in_value,
  input  wire                                in_last_element,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [poc_pkg::OUT_COUNT_W-1:0]    out_occurrence_count,
  output logic                               out_pattern_overflow
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int EXT_W = COUNT_WIDTH + poc_pkg::OUT_COUNT_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PATTERN_MAX);

  logic [LEN_W-1:0]       plen_r, plen_nxt;
  logic [LEN_W-1:0]       load_cnt_r, load_cnt_nxt;
  logic [LEN_W-1:0]       fill_r, fill_nxt, fill_inc;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [COUNT_WIDTH-1:0] out_count_r, out_count_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                   accept, is_text, is_pat, match;
  logic [LEN_W-1:0]       load_base;
  poc_pkg::cell_ctrl_t    ctrl;

  logic [VALUE_WIDTH-1:0] text_link [PATTERN_MAX+1];
  logic [VALUE_WIDTH-1:0] pat_link  [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] hits;
  logic [EXT_W-1:0]       count_ext;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_text  = accept && (in_req_type == poc_pkg::REQ_TEXT);
  assign is_pat   = accept && (in_req_type == poc_pkg::REQ_PATTERN);

  assign load_base = load_cnt_r;
  assign ctrl      = '{text_shift: is_text, pat_shift: is_pat && (load_base < MAX_LEN)};

  assign text_link[0] = in_value;
  assign pat_link[0]  = in_value;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    poc_cell #(
      .IDX         (k),
      .VALUE_WIDTH (VALUE_WIDTH),
      .LEN_W       (LEN_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .text_in  (text_link[k]),
      .text_out (text_link[k+1]),
      .pat_in   (pat_link[k]),
      .pat_out  (pat_link[k+1]),
      .plen     (plen_r),
      .hit      (hits[k])
    );
  end

  assign fill_inc = (fill_r < MAX_LEN) ? fill_r + LEN_W'(1) : fill_r;
  assign match    = (&hits) && (plen_r != '0) && (fill_inc >= plen_r);

  always_comb begin
    plen_nxt      = plen_r;
    load_cnt_nxt  = load_cnt_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    if (is_pat) begin
      if (load_cnt_r == '0) begin
        plen_nxt  = '0;
        ovf_nxt   = 1'b0;
        fill_nxt  = '0;
        total_nxt = '0;
      end
      if (load_cnt_r < MAX_LEN) begin
        load_cnt_nxt = load_cnt_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_last_element) begin
        plen_nxt     = load_cnt_nxt;
        load_cnt_nxt = '0;
      end
    end else if (is_text) begin
      fill_nxt = fill_inc;
      if (match && (total_r != '1)) begin
        total_nxt = total_r + COUNT_WIDTH'(1);
      end
      if (in_last_element) begin
        out_valid_nxt = 1'b1;
        out_count_nxt = total_nxt;
        out_ovf_nxt   = ovf_r;
        total_nxt     = '0;
        fill_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      load_cnt_r  <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      plen_r      <= plen_nxt;
      load_cnt_r  <= load_cnt_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign count_ext            = EXT_W'(out_count_r);
  assign out_valid            = out_valid_r;
  assign out_occurrence_count = count_ext[poc_pkg::OUT_COUNT_W-1:0];
  assign out_pattern_overflow = out_ovf_r;

endmodule

`default_nettype wire

// ===== design/poc_checker.sv =====
// ----------------------------------------------------------------------------
// poc_checker
// Port-level checks of the pattern occurrence counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pattern_occurrence_counter_assert.svh"

module poc_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_stall,
  input wire                                in_req_type,
  input wire                                in_last_element,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire [poc_pkg::OUT_COUNT_W-1:0]     out_occurrence_count
);

  `POC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `POC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_occurrence_count))
  `POC_ASSERT_IMPL(a_stall_only_when_full, in_stall, out_valid && out_stall)
  `POC_ASSERT_NEXT(a_last_text_gives_beat, in_valid && !in_stall && in_last_element && (in_req_type == poc_pkg::REQ_TEXT), out_valid)
  `POC_ASSERT_NEXT(a_pattern_no_beat, in_valid && !in_stall && (in_req_type == poc_pkg::REQ_PATTERN) && !(out_valid && out_stall), !out_valid)

endmodule

bind pattern_occurrence_counter poc_checker u_poc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .in_req_type          (in_req_type),
  .in_last_element      (in_last_element),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_occurrence_count (out_occurrence_count)
);

`default_nettype wire
